// ===== rtl/core/stable_priority_queue_macros.svh =====
// Assertion macros for the stable priority queue checker.
// Clocked on clk, held off while rst_n is low.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Assert that a condition holds at every active edge.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Assert that a trigger implies a consequence on the same edge.
`define SPQ_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Assert that a trigger implies a consequence on the next edge.
`define SPQ_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
// No dependencies.
package spq_pkg;

    localparam int ITEM_W     = 16;
    localparam int PRIO_W     = 32;
    localparam int DEPTH_DEF  = 16;
    localparam int CNT_OUT_W  = 5;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef enum logic
    {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed
    {
        logic signed [PRIO_W-1:0] prio;
        logic [ITEM_W-1:0]        item;
    } slot_t;

    typedef struct packed
    {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted queue: holds a priority and an item, shifts with
// its neighbours. Depends on spq_pkg.
module spq_cell
(
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::slot_t     new_slot,
    input  logic               slot_valid,
    input  logic               left_keep,
    input  spq_pkg::slot_t     left_slot,
    input  spq_pkg::slot_t     right_slot,
    output spq_pkg::slot_t     slot,
    output logic               keep
);
    import spq_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    assign keep = slot_valid && (slot_reg.prio <= new_slot.prio);
    assign slot = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.push)
        begin
            if (!keep)
            begin
                slot_next = left_keep ? new_slot : left_slot;
            end
        end
        else if (ctl.pop)
        begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
// Top level of the stable priority queue: a row of compare-and-shift cells,
// fill count and output register. Depends on spq_pkg and spq_cell.
//
// Usage:
//   in channel: tuser selects push or pop; tdata carries item and priority.
//   out channel: one result item per accepted input item, reporting the
//   popped item, the new head, the entry count and an error code.
//   The head is the smallest priority; equal priorities leave oldest first.
//   The result is registered and appears in the cycle after the input item is accepted.
//   Throughput: one item per cycle unless stalled; every cell compares against
//   the new priority and shifts in the same cycle, so the row finishes in one step.
//   Reset empties the queue (fill count to zero) and drops any pending result;
//   slot contents are left as they are and never read until written.
//   When the receiver stalls, the result holds in the output register and
//   in_tready falls until it is taken.
//   A push to a full queue is dropped and flagged; a pop of an empty queue
//   is flagged and changes nothing.
module stable_priority_queue
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_tvalid,
    output logic                           in_tready,
    // [15:0] item, [47:16] prio
    input  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata,
    // [0] req_type
    input  logic                           in_tuser,
    output logic                           out_tvalid,
    input  logic                           out_tready,
    // [15:0] popped_item, [16] popped_valid, [32:17] head_item,
    // [33] head_valid, [38:34] entry_count, [40:39] err_code, [47:41] zero
    output logic [spq_pkg::OUT_DATA_W-1:0] out_tdata
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [OUT_DATA_W-1:0]        out_data_reg;
    logic [OUT_DATA_W-1:0]        out_data_next;

    logic                         accept;
    logic                         is_pop;
    logic                         full;
    logic                         empty;
    cell_ctl_t                    ctl;
    slot_t                        new_slot;
    slot_t                        cells [DEPTH];
    logic                         keeps [DEPTH];
    err_t                         err;
    logic [ITEM_W-1:0]            popped_item;
    logic [ITEM_W-1:0]            head_item;
    logic                         head_valid;
    logic [CNT_W+CNT_OUT_W-1:0]   count_wide;

    assign in_tready = !out_valid_reg || out_tready;
    assign accept    = in_tvalid && in_tready;
    assign is_pop    = (req_t'(in_tuser) == REQ_POP);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign new_slot.item = in_tdata[ITEM_W-1:0];
    assign new_slot.prio = in_tdata[ITEM_W+PRIO_W-1:ITEM_W];

    assign ctl.push = accept && !is_pop && !full;
    assign ctl.pop  = accept && is_pop && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic  left_keep;
            slot_t left_slot;
            slot_t right_slot;

            if (gi == 0)
            begin : g_first
                assign left_keep = 1'b1;
                assign left_slot = new_slot;
            end
            else
            begin : g_mid
                assign left_keep = keeps[gi-1];
                assign left_slot = cells[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_slot = cells[gi];
            end
            else
            begin : g_inner
                assign right_slot = cells[gi+1];
            end

            spq_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .new_slot   (new_slot),
                .slot_valid (CNT_W'(gi) < count_reg),
                .left_keep  (left_keep),
                .left_slot  (left_slot),
                .right_slot (right_slot),
                .slot       (cells[gi]),
                .keep       (keeps[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        err = ERR_OK;
        if (accept && !is_pop && full)
        begin
            err = ERR_FULL;
        end
        else if (accept && is_pop && empty)
        begin
            err = ERR_EMPTY;
        end
    end

    always_comb
    begin
        popped_item = ctl.pop ? cells[0].item : '0;
        head_valid  = (count_next != '0);
        if (!head_valid)
        begin
            head_item = '0;
        end
        else if (ctl.push)
        begin
            head_item = keeps[0] ? cells[0].item : new_slot.item;
        end
        else if (ctl.pop)
        begin
            head_item = cells[1].item;
        end
        else
        begin
            head_item = cells[0].item;
        end
    end

    assign count_wide = {{CNT_OUT_W{1'b0}}, count_next};

    always_comb
    begin
        out_data_next = '0;
        out_data_next[15:0]  = popped_item;
        out_data_next[16]    = ctl.pop;
        out_data_next[32:17] = head_item;
        out_data_next[33]    = head_valid;
        out_data_next[38:34] = count_wide[CNT_OUT_W-1:0];
        out_data_next[40:39] = err;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;

endmodule

// ===== rtl/core/spq_checker.sv =====
// Port-level checks on the stable priority queue, bound to its top level.
// Depends on spq_pkg and stable_priority_queue_macros.svh.
`include "stable_priority_queue_macros.svh"

module spq_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_tvalid,
    input logic                           out_tready,
    input logic [spq_pkg::OUT_DATA_W-1:0] out_tdata
);
    import spq_pkg::*;

    `SPQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled item changed")
    `SPQ_ASSERT_SAME(a_err_legal, out_tvalid, out_tdata[40:39] != 2'd3, "illegal error code")
    `SPQ_ASSERT_SAME(a_err_no_pop, out_tvalid && out_tdata[40:39] != ERR_OK, !out_tdata[16], "pop reported with error")
    `SPQ_ASSERT_SAME(a_head_zero, out_tvalid && !out_tdata[33], out_tdata[32:17] == '0, "head item set on empty queue")

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);

// ===== bench/tb_stable_priority_queue.sv =====
// Testbench for stable_priority_queue: directed table, then random push/pop traffic
// checked against a sorted shadow queue, with idle, stall and back-pressure phases.
// Depends on spq_pkg and the stable_priority_queue RTL.
module tb_stable_priority_queue;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int N_DIR       = 25;
    localparam int PRINT_MAX   = 60;

    // Fields from the top bit down, as packed in out_tdata[40:0].
    typedef struct packed
    {
        err_t              err;
        logic [4:0]        entry_count;
        logic              head_valid;
        logic [ITEM_W-1:0] head_item;
        logic              popped_valid;
        logic [ITEM_W-1:0] popped_item;
    } status_t;

    typedef struct
    {
        req_t                     req;
        logic [ITEM_W-1:0]        item;
        logic signed [PRIO_W-1:0] prio;
        bit                       typed;
        status_t                  want;
    } dir_row_t;

    localparam status_t UNTYPED = '{ERR_OK, 5'd0, 1'b0, 16'h0, 1'b0, 16'h0};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_tvalid;
    logic                  in_tready;
    logic [IN_DATA_W-1:0]  in_tdata;
    logic                  in_tuser;
    logic                  out_tvalid;
    logic                  out_tready = 1'b0;
    logic [OUT_DATA_W-1:0] out_tdata;

    logic signed [PRIO_W-1:0] held_prio [DEPTH_DEF];
    logic [ITEM_W-1:0]        held_item [DEPTH_DEF];
    int                       held;

    status_t status_due [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      idle_pct;
    int      stall_pct;
    logic    hold_rx;

    dir_row_t dir_rows [N_DIR] = '{
        '{REQ_POP,  16'h0000, 32'sh00000000, 1'b1, '{ERR_EMPTY, 5'd0, 1'b0, 16'h0000, 1'b0, 16'h0}},
        '{REQ_PUSH, 16'hFFFF, 32'sh7FFFFFFF, 1'b1, '{ERR_OK, 5'd1, 1'b1, 16'hFFFF, 1'b0, 16'h0}},
        '{REQ_PUSH, 16'h0000, 32'sh80000000, 1'b1, '{ERR_OK, 5'd2, 1'b1, 16'h0000, 1'b0, 16'h0}},
        '{REQ_POP,  16'h0000, 32'sh00000000, 1'b0, UNTYPED},
        '{REQ_PUSH, 16'h1111, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h2222, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h3333, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h8000, -32'sd1,       1'b0, UNTYPED},
        '{REQ_PUSH, 16'h0001, 32'sd0,        1'b0, UNTYPED},
        '{REQ_POP,  16'h0000, 32'sh00000000, 1'b0, UNTYPED},
        '{REQ_POP,  16'h0000, 32'sh00000000, 1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4000, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4001, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4002, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4003, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4004, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4005, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4006, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4007, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4008, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h4009, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h400A, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h400B, 32'sd5,        1'b0, UNTYPED},
        '{REQ_PUSH, 16'h5A5A, 32'sh80000000, 1'b1, '{ERR_FULL, 5'd16, 1'b1, 16'h1111, 1'b0, 16'h0}},
        '{REQ_POP,  16'h0000, 32'sh00000000, 1'b0, UNTYPED}
    };

    stable_priority_queue dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (in_tvalid),
        .in_tready  (in_tready),
        .in_tdata   (in_tdata),
        .in_tuser   (in_tuser),
        .out_tvalid (out_tvalid),
        .out_tready (out_tready),
        .out_tdata  (out_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic status_t next_queue_status(req_t req, logic [ITEM_W-1:0] itm,
                                                  logic signed [PRIO_W-1:0] pr);
        status_t s;
        int      pos;
        s = UNTYPED;
        if (req == REQ_PUSH)
        begin
            if (held == DEPTH_DEF)
                s.err = ERR_FULL;
            else
            begin
                pos = 0;
                while (pos < held && held_prio[pos] <= pr)
                    pos++;
                for (int k = held; k > pos; k--)
                begin
                    held_prio[k] = held_prio[k-1];
                    held_item[k] = held_item[k-1];
                end
                held_prio[pos] = pr;
                held_item[pos] = itm;
                held++;
            end
        end
        else if (held == 0)
            s.err = ERR_EMPTY;
        else
        begin
            s.popped_item  = held_item[0];
            s.popped_valid = 1'b1;
            for (int k = 1; k < held; k++)
            begin
                held_prio[k-1] = held_prio[k];
                held_item[k-1] = held_item[k];
            end
            held--;
        end
        if (held > 0)
        begin
            s.head_item  = held_item[0];
            s.head_valid = 1'b1;
        end
        s.entry_count = 5'(held);
        return s;
    endfunction

    task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_MAX)
            $display("mismatch at cycle %0d: %s got %0h want %0h",
                     cycle_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic offer(req_t req, logic [ITEM_W-1:0] itm, logic signed [PRIO_W-1:0] pr,
                         bit typed, status_t want);
        status_t s;
        while ($urandom_range(99) < idle_pct)
        begin
            in_tvalid <= 1'b0;
            @(posedge clk);
        end
        in_tvalid <= 1'b1;
        in_tuser  <= req;
        in_tdata  <= {pr, itm};
        do
            @(posedge clk);
        while (!in_tready);
        s = next_queue_status(req, itm, pr);
        status_due.insert(status_due.size(), typed ? want : s);
    endtask

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        logic signed [PRIO_W-1:0] pr;
        case ($urandom_range(9))
            0:       pr = 32'sh7FFFFFFF;
            1:       pr = 32'sh80000000;
            2, 3, 4: pr = $urandom;
            default: pr = $urandom_range(6) - 3;
        endcase
        return pr;
    endfunction

    // Bursts lean towards filling, draining or churning the queue.
    task automatic random_phase(int n, int idle, int stall);
        int   push_pct;
        req_t req;
        idle_pct  = idle;
        stall_pct = stall;
        push_pct  = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i % 24 == 0)
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            req = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
            offer(req, ITEM_W'($urandom), pick_prio(), 1'b0, UNTYPED);
        end
    endtask

    always @(posedge clk)
    begin
        out_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL stable_priority_queue");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && out_tvalid && out_tready)
        begin
            got = status_t'(out_tdata[40:0]);
            if (status_due.size() == 0)
                note_mismatch("unexpected result", 32'(got), 32'h0);
            else
            begin
                want = status_due.pop_front();
                if (got.popped_item !== want.popped_item)
                    note_mismatch("popped_item", 32'(got.popped_item), 32'(want.popped_item));
                if (got.popped_valid !== want.popped_valid)
                    note_mismatch("popped_valid", 32'(got.popped_valid), 32'(want.popped_valid));
                if (got.head_item !== want.head_item)
                    note_mismatch("head_item", 32'(got.head_item), 32'(want.head_item));
                if (got.head_valid !== want.head_valid)
                    note_mismatch("head_valid", 32'(got.head_valid), 32'(want.head_valid));
                if (got.entry_count !== want.entry_count)
                    note_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
                if (got.err !== want.err)
                    note_mismatch("err_code", 32'(got.err), 32'(want.err));
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_tvalid      = 1'b0;
        in_tdata       = '0;
        in_tuser       = 1'b0;
        hold_rx        = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        held           = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].req, dir_rows[i].item, dir_rows[i].prio,
                  dir_rows[i].typed, dir_rows[i].want);

        random_phase(110, 0, 0);
        random_phase(110, 46, 0);

        // Hold the receiver off while requests, mostly pushes, keep arriving.
        idle_pct  = 0;
        stall_pct = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (80) @(posedge clk);
                hold_rx <= 1'b0;
            end
            begin
                for (int i = 0; i < 30; i++)
                    offer(($urandom_range(9) < 8) ? REQ_PUSH : REQ_POP,
                          ITEM_W'($urandom), pick_prio(), 1'b0, UNTYPED);
            end
        join

        random_phase(110, 0, 46);
        random_phase(110, 27, 27);

        in_tvalid <= 1'b0;
        stall_pct = 0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS stable_priority_queue");
        else
            $display("FAIL stable_priority_queue");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue.sv
rtl/core/spq_checker.sv
bench/tb_stable_priority_queue.sv
